// File: rtl/core/gtrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtrb_pkg
// Shared types and constants of the group transpose reorder buffer: payload
// structs of both channels, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package gtrb_pkg;

    localparam int DATA_W     = 8;
    localparam int PPG_W      = 13;
    localparam int GC_W       = 7;
    localparam int PIX_W      = 12;
    localparam int GRP_W      = 6;
    localparam int PROD_W     = PPG_W + GC_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_GROUP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT      = 1'b1;

    localparam logic [PPG_W-1:0] PPG_RESET = 13'd256;
    localparam logic [GC_W-1:0]  GC_RESET  = 7'd16;

    typedef struct packed {
        logic              push_req;
        logic [DATA_W-1:0] write_data;
        logic              read_enable;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              data_available;
        logic              pixel_end;
        logic              overrun;
    } t_out;

endpackage
`default_nettype wire

// File: rtl/core/gtrb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gtrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/gtrb_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtrb_out_stage
// Two-entry output stage: result register plus skid register, so a new
// result is taken while the previous one still waits for its transfer.
// ----------------------------------------------------------------------------
module gtrb_out_stage
    import gtrb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_out i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;
    logic take;
    logic load;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign take    = r_out_valid && i_ready;
    assign load    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!load) begin
                r_out_valid <= 1'b0;
            end
        end else if (load) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (load) begin
                r_out <= i_data;
            end
        end else if (load) begin
            if (r_out_valid) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/group_transpose_reorder_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// group_transpose_reorder_buffer
// Corner-turn buffer: values pushed pixel-major with groups interleaved are
// stored in a frame memory and read out group-major.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_in_data  (t_in)
//   out      output     o_out_valid / i_out_ready  o_out_data (t_out)
//   cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// One input transfer per cycle; each gives one result, held in the output
// register or in the skid register. The frame memory is read one step
// ahead at the next read address, its registered data used at the following
// transfer; a same-slot write is bypassed. Input stalls only when two
// results wait. Reset is synchronous; the frame memory needs no clearing.
// ----------------------------------------------------------------------------
module group_transpose_reorder_buffer
    import gtrb_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW   = $clog2(DEPTH);
    localparam int WC_W = $clog2(DEPTH + 1);
    localparam int RA_W = $clog2(DEPTH + 128);
    localparam int CW   = (RA_W > PROD_W) ? RA_W : PROD_W;

    logic [PPG_W-1:0]  r_ppg;
    logic [GC_W-1:0]   r_gc;
    logic [WC_W-1:0]   r_wc;
    logic [GRP_W-1:0]  r_grp;
    logic [PIX_W-1:0]  r_pix;
    logic [RA_W-1:0]   r_ra;
    logic              r_byp_valid;
    logic [DATA_W-1:0] r_byp_value;
    logic              r_rd_oob;

    logic [WC_W-1:0]   n_wc;
    logic [GRP_W-1:0]  n_grp;
    logic [PIX_W-1:0]  n_pix;
    logic [RA_W-1:0]   n_ra;
    logic              n_byp_valid;
    logic              n_rd_oob;

    logic [PROD_W-1:0] total;
    logic [CW-1:0]     wc_ext;
    logic [CW-1:0]     ra_ext;
    logic              avail;
    logic              pop;
    logic              at_pix_end;
    logic              at_grp_end;
    logic              done;
    logic              full;
    logic              we;
    logic [GRP_W-1:0]  g1;
    logic [DATA_W-1:0] ram_q;
    logic [DATA_W-1:0] rd_value;
    logic              step;
    logic              stage_ready;
    t_out              res;

    assign o_in_ready = stage_ready;
    assign step       = i_in_valid && stage_ready;

    always_comb begin
        total      = PROD_W'(r_ppg) * PROD_W'(r_gc);
        wc_ext     = CW'(r_wc);
        ra_ext     = CW'(r_ra);
        avail      = wc_ext > ra_ext;
        pop        = i_in_data.read_enable && avail;
        at_pix_end = (r_ppg != '0) && ({1'b0, r_pix} == (r_ppg - PPG_W'(1)));
        at_grp_end = (r_gc != '0) && ({1'b0, r_grp} == (r_gc - GC_W'(1)));
        done       = pop && at_pix_end && at_grp_end;
        full       = (wc_ext >= CW'(total)) || (wc_ext >= CW'(DEPTH));
        we         = i_in_data.push_req && !full;
        g1         = r_grp + GRP_W'(1);

        n_grp = r_grp;
        n_pix = r_pix;
        n_ra  = r_ra;
        if (pop) begin
            if (at_pix_end) begin
                n_pix = '0;
                n_grp = at_grp_end ? '0 : g1;
                n_ra  = at_grp_end ? '0 : RA_W'(g1);
            end else begin
                n_pix = r_pix + PIX_W'(1);
                n_ra  = r_ra + RA_W'(r_gc);
            end
        end

        if (done) begin
            n_wc = '0;
        end else if (we) begin
            n_wc = r_wc + WC_W'(1);
        end else begin
            n_wc = r_wc;
        end

        n_byp_valid = we && (wc_ext == CW'(n_ra));
        n_rd_oob    = CW'(n_ra) >= CW'(DEPTH);

        if (r_byp_valid) begin
            rd_value = r_byp_value;
        end else if (r_rd_oob) begin
            rd_value = '0;
        end else begin
            rd_value = ram_q;
        end

        res.read_data      = avail ? rd_value : '0;
        res.data_available = avail;
        res.pixel_end      = at_pix_end;
        res.overrun        = i_in_data.push_req && full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppg <= PPG_RESET;
            r_gc  <= GC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXELS_PER_GROUP: r_ppg <= i_cfg_wdata[PPG_W-1:0];
                CFG_GROUP_COUNT:      r_gc  <= i_cfg_wdata[GC_W-1:0];
                default:              r_ppg <= r_ppg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc        <= '0;
            r_grp       <= '0;
            r_pix       <= '0;
            r_ra        <= '0;
            r_byp_valid <= 1'b0;
            r_byp_value <= '0;
            r_rd_oob    <= 1'b0;
        end else if (step) begin
            r_wc        <= n_wc;
            r_grp       <= n_grp;
            r_pix       <= n_pix;
            r_ra        <= n_ra;
            r_byp_valid <= n_byp_valid;
            r_byp_value <= i_in_data.write_data;
            r_rd_oob    <= n_rd_oob;
        end
    end

    gtrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (step && we),
        .i_waddr (r_wc[AW-1:0]),
        .i_wdata (i_in_data.write_data),
        .i_re    (step),
        .i_raddr (n_ra[AW-1:0]),
        .o_rdata (ram_q)
    );

    gtrb_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (stage_ready),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire

// File: verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the group transpose reorder buffer. A transfer-level
// predictor follows every input transfer and queues the expected result; each
// output transfer is compared field by field against the oldest entry.
// Directed items cover full frames, overrun, bypass, zero registers, register
// change mid-frame and group wrap, then random phases over several settings
// and a final unpaused burst on a large frame.
// ----------------------------------------------------------------------------
module tb;
    import gtrb_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int COUNT_W     = 13;
    localparam int ADDR_W      = 13;
    localparam int CYCLE_LIMIT = 1_000_000;

    class reorder_tracker;
        bit [PPG_W-1:0]   ppg;
        bit [GC_W-1:0]    gc;
        bit [COUNT_W-1:0] wr_count;
        bit [GRP_W-1:0]   rd_group;
        bit [PIX_W-1:0]   rd_pixel;
        bit [ADDR_W-1:0]  rd_addr;
        bit [DATA_W-1:0]  store [STORE_DEPTH];
        bit [DATA_W-1:0]  rd_reg;
        bit               byp_valid;
        bit [DATA_W-1:0]  byp_val;
        t_out             pending_outputs [$];
        int               mismatches;
        int               checked;

        function new();
            ppg = PPG_RESET;
            gc  = GC_RESET;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
            if (idx == CFG_PIXELS_PER_GROUP) begin
                ppg = word[PPG_W-1:0];
            end else begin
                gc = word[GC_W-1:0];
            end
        endfunction

        function bit frame_empty();
            return wr_count == '0 && rd_addr == '0 && rd_group == '0 && rd_pixel == '0;
        endfunction

        function int outstanding();
            return pending_outputs.size();
        endfunction

        function void note_transfer(t_in it);
            logic [PROD_W-1:0]  total;
            logic [PROD_W-1:0]  cap;
            logic               avail;
            logic               pop;
            logic               at_pix_end;
            logic               at_grp_end;
            logic               done;
            logic               full;
            logic               wen;
            logic [GRP_W-1:0]   g1;
            logic [GRP_W-1:0]   grp_n;
            logic [PIX_W-1:0]   pix_n;
            logic [ADDR_W-1:0]  addr_n;
            logic [COUNT_W-1:0] wc_n;
            t_out               res;

            total      = PROD_W'(ppg) * PROD_W'(gc);
            cap        = (total < PROD_W'(STORE_DEPTH)) ? total : PROD_W'(STORE_DEPTH);
            avail      = wr_count > rd_addr;
            pop        = it.read_enable && avail;
            at_pix_end = ppg != '0 && {1'b0, rd_pixel} == ppg - 13'd1;
            at_grp_end = gc != '0 && {1'b0, rd_group} == gc - 7'd1;
            done       = pop && at_pix_end && at_grp_end;

            res.read_data      = avail ? (byp_valid ? byp_val : rd_reg) : '0;
            res.data_available = avail;
            res.pixel_end      = at_pix_end;

            grp_n  = rd_group;
            pix_n  = rd_pixel;
            addr_n = rd_addr;
            if (pop) begin
                if (at_pix_end) begin
                    g1     = rd_group + 6'd1;
                    pix_n  = '0;
                    grp_n  = at_grp_end ? '0 : g1;
                    addr_n = at_grp_end ? '0 : {7'd0, g1};
                end else begin
                    pix_n  = rd_pixel + 12'd1;
                    addr_n = rd_addr + {6'd0, gc};
                end
            end

            full        = PROD_W'(wr_count) >= cap;
            wen         = it.push_req && !full;
            res.overrun = it.push_req && full;
            wc_n        = done ? '0 : (wen ? wr_count + 13'd1 : wr_count);

            rd_reg    = (addr_n < ADDR_W'(STORE_DEPTH)) ? store[addr_n[PIX_W-1:0]] : '0;
            byp_valid = wen && wr_count == addr_n;
            byp_val   = it.write_data;
            if (wen && wr_count < COUNT_W'(STORE_DEPTH)) begin
                store[wr_count[PIX_W-1:0]] = it.write_data;
            end

            wr_count = wc_n;
            rd_group = grp_n;
            rd_pixel = pix_n;
            rd_addr  = addr_n;
            pending_outputs.push_back(res);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 100) begin
                $display("tb: mismatch at result %0d: %s", checked, what);
            end
        endtask

        task check_output(t_out got);
            t_out want;
            checked++;
            if (pending_outputs.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = pending_outputs.pop_front();
            if (got.read_data !== want.read_data) begin
                report($sformatf("read_data exp %h got %h", want.read_data, got.read_data));
            end
            if (got.data_available !== want.data_available) begin
                report($sformatf("data_available exp %b got %b",
                                 want.data_available, got.data_available));
            end
            if (got.pixel_end !== want.pixel_end) begin
                report($sformatf("pixel_end exp %b got %b", want.pixel_end, got.pixel_end));
            end
            if (got.overrun !== want.overrun) begin
                report($sformatf("overrun exp %b got %b", want.overrun, got.overrun));
            end
        endtask
    endclass

    bit                    clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    bit                    idling;
    reorder_tracker        tracker;

    group_transpose_reorder_buffer #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : output_side
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            tracker.check_output(out_data);
        end
    end

    task automatic offer_input(input logic push, input logic [DATA_W-1:0] value,
                               input logic rd);
        t_in item;
        item.push_req    = push;
        item.write_data  = value;
        item.read_enable = rd;
        if (idling && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_transfer(item);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] word;
        word = value;
        if (idx == CFG_GROUP_COUNT) begin
            word             = CFG_DATA_W'($urandom);
            word[GC_W-1:0]   = value[GC_W-1:0];
        end
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= word;
        @(posedge clk);
        tracker.write_register(idx, word);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_frame();
        while (!tracker.frame_empty()) begin
            offer_input(1'b1, DATA_W'($urandom), 1'b1);
        end
    endtask

    initial begin : stimulus
        int                push_pct;
        int                read_pct;
        logic [PPG_W-1:0]  ppg_v;
        logic [GC_W-1:0]   gc_v;

        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        idling    = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, empty store
        offer_input(1'b0, 8'h00, 1'b1);
        offer_input(1'b0, 8'hFF, 1'b0);
        settle();

        // two by two frame: bypass, full frame, overrun, release on last pop
        program_reg(CFG_PIXELS_PER_GROUP, 13'd2);
        program_reg(CFG_GROUP_COUNT, 13'd2);
        offer_input(1'b1, 8'h00, 1'b1);
        offer_input(1'b1, 8'hFF, 1'b1);
        offer_input(1'b1, 8'h55, 1'b1);
        offer_input(1'b1, 8'hAA, 1'b1);
        offer_input(1'b1, 8'h0F, 1'b0);
        offer_input(1'b1, 8'hF0, 1'b1);
        offer_input(1'b1, 8'h3C, 1'b1);
        offer_input(1'b1, 8'hC3, 1'b0);
        drain_frame();

        // widen the frame mid-way
        offer_input(1'b1, 8'h81, 1'b0);
        offer_input(1'b1, 8'h7E, 1'b0);
        settle();
        program_reg(CFG_PIXELS_PER_GROUP, 13'd3);
        drain_frame();
        settle();

        // zero registers
        program_reg(CFG_PIXELS_PER_GROUP, 13'd0);
        offer_input(1'b1, 8'h12, 1'b1);
        offer_input(1'b1, 8'hED, 1'b1);
        offer_input(1'b0, 8'h00, 1'b1);
        settle();
        program_reg(CFG_GROUP_COUNT, 13'd0);
        program_reg(CFG_PIXELS_PER_GROUP, 13'd1);
        offer_input(1'b1, 8'h99, 1'b1);
        offer_input(1'b1, 8'h66, 1'b0);
        settle();

        // group pointer wraps before the last group is reached
        program_reg(CFG_GROUP_COUNT, 13'd127);
        repeat (130) offer_input(1'b1, DATA_W'($urandom), 1'b1);
        settle();
        program_reg(CFG_PIXELS_PER_GROUP, CFG_DATA_W'({1'b0, tracker.rd_pixel} + 13'd1));
        program_reg(CFG_GROUP_COUNT, CFG_DATA_W'({1'b0, tracker.rd_group} + 7'd1));
        drain_frame();
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            ppg_v = PPG_W'($urandom_range(1, 8));
            gc_v  = GC_W'($urandom_range(1, 8));
            if (ph == 0) begin
                ppg_v = 13'd1;
                gc_v  = 7'd1;
            end else if (ph == 1) begin
                ppg_v = PPG_W'($urandom_range(1, 4));
                gc_v  = 7'd64;
            end else if (ph == 2) begin
                ppg_v = 13'd64;
                gc_v  = 7'd1;
            end
            program_reg(CFG_PIXELS_PER_GROUP, ppg_v);
            program_reg(CFG_GROUP_COUNT, CFG_DATA_W'(gc_v));
            push_pct = $urandom_range(30, 90);
            read_pct = $urandom_range(30, 90);
            repeat (48) begin
                offer_input($urandom_range(0, 99) < push_pct, DATA_W'($urandom),
                            $urandom_range(0, 99) < read_pct);
            end
            settle();
            drain_frame();
            settle();
        end

        // no idling: large frame, pixel end never reached
        idling = 1'b0;
        program_reg(CFG_PIXELS_PER_GROUP, 13'h1FFF);
        program_reg(CFG_GROUP_COUNT, 13'd1);
        repeat (120) offer_input(1'b1, DATA_W'($urandom), 1'b1);
        settle();

        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
